>>> rtl/core/tcgr_pkg.sv
// Shared types, constants and the color palette of the text cell glyph renderer.
`timescale 1ns / 1ps

package tcgr_pkg;

  // Default parameter values.
  localparam int FONT_BYTES_DEF   = 4096;
  localparam int GLYPH_HEIGHT_DEF = 16;
  localparam int GRID_COLS_DEF    = 80;
  localparam int GRID_ROWS_DEF    = 26;
  localparam int ADDR_BITS_DEF    = 23;

  // Fixed geometry and field widths.
  localparam int GLYPH_WIDTH = 8;
  localparam int PIXEL_W     = 24;
  localparam int SCREEN_W    = 13;
  localparam int PITCH_W     = 15;
  localparam int CFG_DATA_W  = 15;

  // Operation codes of an input word.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RENDER_ENABLE = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2,
    CFG_LINE_PITCH    = 2'd3
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic font_wr;    // store the font byte of the current input word
    logic cell_load;  // capture a render word
    logic setup;      // form the start address of the cell
    logic emit;       // move one glyph row into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // output register is empty or is being taken
    logic last_row;   // the row in flight is the final one of the cell
  } ctl_sts_t;

  // Fixed 16-color text palette, red 23:16, green 15:8, blue 7:0.
  function automatic logic [PIXEL_W-1:0] palette_color(input logic [3:0] code);
    logic [PIXEL_W-1:0] color;
    case (code)
      4'd0:    color = 24'h000000;
      4'd1:    color = 24'h0000aa;
      4'd2:    color = 24'h00aa00;
      4'd3:    color = 24'h00aaaa;
      4'd4:    color = 24'haa0000;
      4'd5:    color = 24'haa00aa;
      4'd6:    color = 24'haa5500;
      4'd7:    color = 24'haaaaaa;
      4'd8:    color = 24'h555555;
      4'd9:    color = 24'h5555ff;
      4'd10:   color = 24'h55ff55;
      4'd11:   color = 24'h55ffff;
      4'd12:   color = 24'hff5555;
      4'd13:   color = 24'hff55ff;
      4'd14:   color = 24'hffff00;
      default: color = 24'hffffff;
    endcase
    return color;
  endfunction

endpackage

>>> rtl/core/tcgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/tcgr_ctrl.sv
// Controller state machine that sequences font loads and cell expansion.
`timescale 1ns / 1ps

module tcgr_ctrl
  import tcgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_operation,
  input  logic     render_enable,
  input  ctl_sts_t sts,
  output logic     in_stall,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation == OP_RENDER && render_enable) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.slot_free && sts.last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.font_wr   = in_valid && in_operation == OP_LOAD;
        cmd.cell_load = in_valid && in_operation == OP_RENDER && render_enable;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_RUN: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/tcgr_datapath.sv
// Datapath: font store, cell address arithmetic, glyph row expansion and output register.
`timescale 1ns / 1ps

module tcgr_datapath
  import tcgr_pkg::*;
#(
  parameter int FONT_BYTES   = FONT_BYTES_DEF,
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int GRID_COLS    = GRID_COLS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             cmd,
  output ctl_sts_t             sts,
  input  logic [SCREEN_W-1:0]  screen_width,
  input  logic [SCREEN_W-1:0]  screen_height,
  input  logic [PITCH_W-1:0]   line_pitch,
  input  logic [11:0]          in_font_index,
  input  logic [7:0]           in_font_byte,
  input  logic [7:0]           in_char_code,
  input  logic [7:0]           in_attribute,
  input  logic [6:0]           in_cell_col,
  input  logic [4:0]           in_cell_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_BITS-1:0] out_row_address,
  output logic [PIXEL_W-1:0]   out_pixel_0,
  output logic [PIXEL_W-1:0]   out_pixel_1,
  output logic [PIXEL_W-1:0]   out_pixel_2,
  output logic [PIXEL_W-1:0]   out_pixel_3,
  output logic [PIXEL_W-1:0]   out_pixel_4,
  output logic [PIXEL_W-1:0]   out_pixel_5,
  output logic [PIXEL_W-1:0]   out_pixel_6,
  output logic [PIXEL_W-1:0]   out_pixel_7,
  output logic                 out_last_row
);

  localparam int FA      = $clog2(FONT_BYTES);
  localparam int RW      = $clog2(GLYPH_HEIGHT);
  localparam int GS_W    = 14;  // holds any glyph byte number and FONT_BYTES itself
  localparam int XPIX_W  = 14;
  localparam int XBYTE_W = 16;
  localparam int YPIX_W  = 14;
  localparam int SUM_W   = 30;
  localparam int GRID_W_PX = GRID_COLS * GLYPH_WIDTH;
  localparam int GRID_H_PX = GRID_ROWS * GLYPH_HEIGHT;

  logic [PIXEL_W-1:0]   fg_r, bg_r;
  logic [XBYTE_W-1:0]   xbytes_r;
  logic [YPIX_W-1:0]    ybase_r;
  logic [FA-1:0]        ptr_r, ptr_inc;
  logic [RW-1:0]        row_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic [PIXEL_W-1:0]   pixel_r [GLYPH_WIDTH];
  logic                 out_last_r;

  logic [SCREEN_W-1:0]  ox, oy;
  logic [XPIX_W-1:0]    xpix;
  logic [XBYTE_W-1:0]   xbytes;
  logic [YPIX_W-1:0]    ybase;
  logic [GS_W-1:0]      gbase;
  logic [GS_W-1:0]      fidx;
  logic [FA:0]          ptr_plus;
  logic [FA-1:0]        rd_addr;
  logic [7:0]           glyph_bits;
  logic [SUM_W-1:0]     start_sum;

  // Centering offsets; zero when the screen is no larger than the grid.
  always_comb begin
    ox = '0;
    oy = '0;
    if (screen_width > SCREEN_W'(GRID_W_PX)) begin
      ox = (screen_width - SCREEN_W'(GRID_W_PX)) >> 1;
    end
    if (screen_height > SCREEN_W'(GRID_H_PX)) begin
      oy = (screen_height - SCREEN_W'(GRID_H_PX)) >> 1;
    end
  end

  assign xpix   = XPIX_W'(ox) + XPIX_W'({in_cell_col, 3'b000});
  assign xbytes = XBYTE_W'({xpix, 1'b0}) + XBYTE_W'(xpix);
  assign ybase  = YPIX_W'(oy) + YPIX_W'(in_cell_row) * YPIX_W'(GLYPH_HEIGHT);

  // First glyph byte of the character, reduced into the font store by a few
  // conditional subtractions.
  always_comb begin
    gbase = GS_W'(in_char_code) * GS_W'(GLYPH_HEIGHT);
    for (int i = 0; i < 4; i++) begin
      if (gbase >= GS_W'(FONT_BYTES)) begin
        gbase = gbase - GS_W'(FONT_BYTES);
      end
    end
  end

  always_comb begin
    fidx = GS_W'(in_font_index);
    if (fidx >= GS_W'(FONT_BYTES)) begin
      fidx = fidx - GS_W'(FONT_BYTES);
    end
  end

  assign ptr_plus = {1'b0, ptr_r} + (FA+1)'(1);
  assign ptr_inc  = (ptr_plus == (FA+1)'(FONT_BYTES)) ? '0 : ptr_plus[FA-1:0];
  // The read port keeps showing the byte of the pending row until it is emitted.
  assign rd_addr  = cmd.emit ? ptr_inc : ptr_r;

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk     (clk),
    .wr_en   (cmd.font_wr),
    .wr_addr (fidx[FA-1:0]),
    .wr_data (in_font_byte),
    .rd_addr (rd_addr),
    .rd_data (glyph_bits)
  );

  assign start_sum = SUM_W'(ybase_r) * SUM_W'(line_pitch) + SUM_W'(xbytes_r);

  always_ff @(posedge clk) begin
    if (cmd.cell_load) begin
      fg_r     <= palette_color(in_attribute[3:0]);
      bg_r     <= palette_color(in_attribute[7:4]);
      xbytes_r <= xbytes;
      ybase_r  <= ybase;
      ptr_r    <= gbase[FA-1:0];
    end else if (cmd.emit) begin
      ptr_r <= ptr_inc;
    end
    if (cmd.setup) begin
      addr_r <= ADDR_BITS'(start_sum);
    end else if (cmd.emit) begin
      addr_r <= addr_r + ADDR_BITS'(line_pitch);
    end
    if (cmd.emit) begin
      out_addr_r <= addr_r;
      out_last_r <= (row_r == RW'(GLYPH_HEIGHT - 1));
      for (int k = 0; k < GLYPH_WIDTH; k++) begin
        pixel_r[k] <= glyph_bits[GLYPH_WIDTH-1-k] ? fg_r : bg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.cell_load) begin
        row_r <= '0;
      end else if (cmd.emit) begin
        row_r <= row_r + RW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.last_row  = (row_r == RW'(GLYPH_HEIGHT - 1));

  assign out_valid       = out_valid_r;
  assign out_row_address = out_addr_r;
  assign out_pixel_0     = pixel_r[0];
  assign out_pixel_1     = pixel_r[1];
  assign out_pixel_2     = pixel_r[2];
  assign out_pixel_3     = pixel_r[3];
  assign out_pixel_4     = pixel_r[4];
  assign out_pixel_5     = pixel_r[5];
  assign out_pixel_6     = pixel_r[6];
  assign out_pixel_7     = pixel_r[7];
  assign out_last_row    = out_last_r;

endmodule

>>> rtl/core/text_cell_glyph_renderer_unit.sv
// Top level of the text cell glyph renderer: configuration registers, controller and datapath.
// A render word is taken while the controller is idle, its start address is formed in the
// setup state, and its glyph rows then move into the output register in the run state, each
// once that register can take it; the font store yields one row byte per cycle. No new input
// word is taken until the final row of the cell has gone into the output register.
// A font load is written in the accepting cycle.
// Reset (rst_n, synchronous, active low) returns the controller to idle, empties the
// output register and restores the configuration defaults; the font store is not cleared.
`timescale 1ns / 1ps

module text_cell_glyph_renderer_unit
  import tcgr_pkg::*;
#(
  parameter int FONT_BYTES   = FONT_BYTES_DEF,
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int GRID_COLS    = GRID_COLS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input word channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [11:0]           in_font_index,
  input  logic [7:0]            in_font_byte,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_attribute,
  input  logic [6:0]            in_cell_col,
  input  logic [4:0]            in_cell_row,
  // Result word channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_BITS-1:0]  out_row_address,
  output logic [PIXEL_W-1:0]    out_pixel_0,
  output logic [PIXEL_W-1:0]    out_pixel_1,
  output logic [PIXEL_W-1:0]    out_pixel_2,
  output logic [PIXEL_W-1:0]    out_pixel_3,
  output logic [PIXEL_W-1:0]    out_pixel_4,
  output logic [PIXEL_W-1:0]    out_pixel_5,
  output logic [PIXEL_W-1:0]    out_pixel_6,
  output logic [PIXEL_W-1:0]    out_pixel_7,
  output logic                  out_last_row
);

  // Configuration registers. Every write is taken at once; each register keeps
  // only as many low bits of the written word as it is wide.
  logic                cfg_render_enable_r;
  logic [SCREEN_W-1:0] cfg_screen_width_r;
  logic [SCREEN_W-1:0] cfg_screen_height_r;
  logic [PITCH_W-1:0]  cfg_line_pitch_r;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_render_enable_r <= 1'b0;
      cfg_screen_width_r  <= SCREEN_W'(640);
      cfg_screen_height_r <= SCREEN_W'(480);
      cfg_line_pitch_r    <= PITCH_W'(1920);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RENDER_ENABLE: cfg_render_enable_r <= cfg_data[0];
        CFG_SCREEN_WIDTH:  cfg_screen_width_r  <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_screen_height_r <= cfg_data[SCREEN_W-1:0];
        CFG_LINE_PITCH:    cfg_line_pitch_r    <= cfg_data[PITCH_W-1:0];
        default: begin
          cfg_render_enable_r <= cfg_render_enable_r;
        end
      endcase
    end
  end

  // The controller takes input words only when idle. A font load is written
  // in the accepting cycle, a render word with rendering disabled is dropped,
  // and an enabled render word forms its start address in the setup state and
  // then emits one glyph row word per cycle whenever the output register can
  // take it.
  tcgr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_operation  (in_operation),
    .render_enable (cfg_render_enable_r),
    .sts           (sts),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  // The datapath holds the font store and the output register, so the final
  // row of a cell can wait downstream while the next word is accepted. The
  // last-row flag is carried beside the output register.
  tcgr_datapath #(
    .FONT_BYTES   (FONT_BYTES),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GRID_COLS    (GRID_COLS),
    .GRID_ROWS    (GRID_ROWS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .screen_width    (cfg_screen_width_r),
    .screen_height   (cfg_screen_height_r),
    .line_pitch      (cfg_line_pitch_r),
    .in_font_index   (in_font_index),
    .in_font_byte    (in_font_byte),
    .in_char_code    (in_char_code),
    .in_attribute    (in_attribute),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_address (out_row_address),
    .out_pixel_0     (out_pixel_0),
    .out_pixel_1     (out_pixel_1),
    .out_pixel_2     (out_pixel_2),
    .out_pixel_3     (out_pixel_3),
    .out_pixel_4     (out_pixel_4),
    .out_pixel_5     (out_pixel_5),
    .out_pixel_6     (out_pixel_6),
    .out_pixel_7     (out_pixel_7),
    .out_last_row    (out_last_row)
  );

  // An enabled render word always makes the block busy in the next cycle.
  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_RENDER && cfg_render_enable_r)
    |=> in_stall)
    else $error("render word accepted but block did not go busy");

  // While idle with an empty output, no result word can appear.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && !out_valid) |=> !out_valid)
    else $error("result word appeared while idle");

  // The block leaves idle only on an accepted, enabled render word.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && $past(!in_stall) && $past(rst_n))
    |-> $past(in_valid && in_operation == OP_RENDER && cfg_render_enable_r))
    else $error("block went busy without an enabled render word");

endmodule

>>> bench/tb_text_cell_glyph_renderer_unit.sv
// Self-checking testbench for the text cell glyph renderer unit.
`timescale 1ns / 1ps

module tb_text_cell_glyph_renderer_unit;
  import tcgr_pkg::*;

  // Grid size in pixels on each axis, used to centre the grid on the screen.
  localparam int GRID_PIX_W = GRID_COLS_DEF * GLYPH_WIDTH;
  localparam int GRID_PIX_H = GRID_ROWS_DEF * GLYPH_HEIGHT_DEF;
  // Cycles to let pass once the last expected word is in, so that font loads and
  // renders that produce nothing have finished before a register write or the end.
  localparam int DRAIN_CYCLES = GLYPH_HEIGHT_DEF + 8;
  localparam int PHASE_WORDS = 16;

  // The fixed text palette, red 23:16, green 15:8, blue 7:0.
  localparam logic [PIXEL_W-1:0] TEXT_COLORS [16] = '{
    24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
    24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
    24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
    24'hff5555, 24'hff55ff, 24'hffff00, 24'hffffff
  };

  // Glyph row patterns used for the two glyphs loaded before the directed part.
  localparam logic [7:0] ROW_PATTERNS [6] = '{8'h80, 8'h0f, 8'haa, 8'h55, 8'hff, 8'h00};

  typedef struct packed {
    logic       op;
    logic [11:0] font_index;
    logic [7:0] font_byte;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
  } cell_word_t;

  typedef struct packed {
    logic [ADDR_BITS_DEF-1:0]      addr;
    logic [7:0][PIXEL_W-1:0]       px;
    logic                          last;
  } glyph_row_t;

  typedef enum logic {
    STEP_CONFIG,
    STEP_WORD
  } plan_kind_t;

  // One line of the directed plan. Where typed is set, the address and leftmost
  // pixel of the first glyph row are written out by hand instead of predicted.
  typedef struct packed {
    plan_kind_t               kind;
    cfg_idx_t                 reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    cell_word_t               word;
    logic                     typed;
    logic [ADDR_BITS_DEF-1:0] addr0;
    logic [PIXEL_W-1:0]       pixel0;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index = CFG_RENDER_ENABLE;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_operation = OP_LOAD;
  logic [11:0]              in_font_index = '0;
  logic [7:0]               in_font_byte = '0;
  logic [7:0]               in_char_code = '0;
  logic [7:0]               in_attribute = '0;
  logic [6:0]               in_cell_col = '0;
  logic [4:0]               in_cell_row = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ADDR_BITS_DEF-1:0] out_row_address;
  logic [PIXEL_W-1:0]       out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3;
  logic [PIXEL_W-1:0]       out_pixel_4, out_pixel_5, out_pixel_6, out_pixel_7;
  logic                     out_last_row;

  text_cell_glyph_renderer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_font_index   (in_font_index),
    .in_font_byte    (in_font_byte),
    .in_char_code    (in_char_code),
    .in_attribute    (in_attribute),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_address (out_row_address),
    .out_pixel_0     (out_pixel_0),
    .out_pixel_1     (out_pixel_1),
    .out_pixel_2     (out_pixel_2),
    .out_pixel_3     (out_pixel_3),
    .out_pixel_4     (out_pixel_4),
    .out_pixel_5     (out_pixel_5),
    .out_pixel_6     (out_pixel_6),
    .out_pixel_7     (out_pixel_7),
    .out_last_row    (out_last_row)
  );

  // Our own copy of the block's state: font store, the glyphs fully loaded,
  // and the four configuration registers as last written.
  logic [7:0]  font_copy [FONT_BYTES_DEF];
  bit          glyph_ready [256];
  logic [7:0]  ready_chars [$];
  logic        exp_enable = 1'b0;
  int unsigned exp_width = 640;
  int unsigned exp_height = 480;
  int unsigned exp_pitch = 1920;

  // Glyph rows still owed by the block, oldest first.
  glyph_row_t  pending_rows [$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_count = 0;
  int          loads_sent = 0;
  int          renders_sent = 0;
  int          rows_checked = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Expand one render word into its sixteen glyph rows and queue them. The grid is
  // centred on each axis, or pinned to zero where the screen is smaller than the grid,
  // and every address wraps at the width of the address bus.
  function automatic void predict_cell_rows(input cell_word_t w);
    longint unsigned ox, oy, xbytes, y, addr;
    int unsigned     fidx;
    logic [7:0]      bits;
    logic [PIXEL_W-1:0] fg, bg;
    glyph_row_t      r;
    ox = (exp_width > GRID_PIX_W) ? (exp_width - GRID_PIX_W) / 2 : 0;
    oy = (exp_height > GRID_PIX_H) ? (exp_height - GRID_PIX_H) / 2 : 0;
    xbytes = (ox + longint'(w.cell_col) * GLYPH_WIDTH) * 3;
    fg = TEXT_COLORS[w.attribute[3:0]];
    bg = TEXT_COLORS[w.attribute[7:4]];
    for (int gy = 0; gy < GLYPH_HEIGHT_DEF; gy++) begin
      fidx = (int'(w.char_code) * GLYPH_HEIGHT_DEF + gy) % FONT_BYTES_DEF;
      bits = font_copy[fidx];
      y = oy + longint'(w.cell_row) * GLYPH_HEIGHT_DEF + gy;
      addr = y * exp_pitch + xbytes;
      r.addr = addr[ADDR_BITS_DEF-1:0];
      // The most significant font bit is the leftmost pixel.
      for (int gx = 0; gx < GLYPH_WIDTH; gx++) begin
        r.px[gx] = bits[7-gx] ? fg : bg;
      end
      r.last = (gy == GLYPH_HEIGHT_DEF - 1);
      pending_rows.push_back(r);
    end
  endfunction

  // Present one input word and hold it until the block takes it. Inputs move at the
  // falling edge; acceptance is judged from in_stall as it stood at the rising edge.
  task automatic send_word(input cell_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= w.op;
    in_font_index <= w.font_index;
    in_font_byte  <= w.font_byte;
    in_char_code  <= w.char_code;
    in_attribute  <= w.attribute;
    in_cell_col   <= w.cell_col;
    in_cell_row   <= w.cell_row;
    do @(posedge clk); while (in_stall);
    if (w.op == OP_LOAD) begin
      font_copy[w.font_index] = w.font_byte;
      loads_sent++;
    end else begin
      renders_sent++;
      // A render while disabled gives nothing and leaves the state alone.
      if (exp_enable) predict_cell_rows(w);
    end
  endtask

  // Stop feeding words and wait until the block has nothing left to do.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_until_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RENDER_ENABLE: exp_enable = val[0];
      CFG_SCREEN_WIDTH:  exp_width  = 32'(val[SCREEN_W-1:0]);
      CFG_SCREEN_HEIGHT: exp_height = 32'(val[SCREEN_W-1:0]);
      default:           exp_pitch  = 32'(val[PITCH_W-1:0]);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cell_word_t random_word();
    cell_word_t w;
    w.op         = 1'($urandom_range(1));
    w.font_index = 12'($urandom);
    w.font_byte  = 8'($urandom);
    w.char_code  = 8'($urandom);
    w.attribute  = 8'($urandom);
    w.cell_col   = 7'($urandom);
    w.cell_row   = 5'($urandom);
    return w;
  endfunction

  function automatic plan_row_t config_step(input cfg_idx_t idx,
                                            input logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.kind    = STEP_CONFIG;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t load_step(input logic [11:0] idx, input logic [7:0] fbyte);
    plan_row_t p;
    p = '0;
    p.kind            = STEP_WORD;
    p.word.op         = OP_LOAD;
    p.word.font_index = idx;
    p.word.font_byte  = fbyte;
    return p;
  endfunction

  function automatic plan_row_t render_step(input logic [7:0] ch, input logic [7:0] attr,
                                            input logic [6:0] col, input logic [4:0] row,
                                            input logic typed,
                                            input logic [ADDR_BITS_DEF-1:0] addr0,
                                            input logic [PIXEL_W-1:0] pixel0);
    plan_row_t p;
    p = '0;
    p.kind           = STEP_WORD;
    p.word.op        = OP_RENDER;
    p.word.char_code = ch;
    p.word.attribute = attr;
    p.word.cell_col  = col;
    p.word.cell_row  = row;
    p.typed          = typed;
    p.addr0          = addr0;
    p.pixel0         = pixel0;
    return p;
  endfunction

  // The receiver stalls at random at the rate the current phase sets.
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Every word the block hands over is matched against the oldest glyph row owed.
  always @(posedge clk) begin : check_rows
    glyph_row_t want;
    logic [7:0][PIXEL_W-1:0] got_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        $error("result word with none expected: row_address %h", out_row_address);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        got_px = {out_pixel_7, out_pixel_6, out_pixel_5, out_pixel_4,
                  out_pixel_3, out_pixel_2, out_pixel_1, out_pixel_0};
        rows_checked++;
        if (out_row_address !== want.addr) begin
          $error("row_address: expected %h, got %h", want.addr, out_row_address);
          fail_count++;
        end
        for (int i = 0; i < GLYPH_WIDTH; i++) begin
          if (got_px[i] !== want.px[i]) begin
            $error("pixel_%0d: expected %h, got %h", i, want.px[i], got_px[i]);
            fail_count++;
          end
        end
        if (out_last_row !== want.last) begin
          $error("last_row: expected %b, got %b", want.last, out_last_row);
          fail_count++;
        end
      end
    end
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #5_000_000;
    $display("** text_cell_glyph_renderer_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    plan_row_t  directed_plan [26];
    glyph_row_t r;
    cell_word_t w;
    int         k;
    int         pick;
    int         phase_words;
    logic [7:0] ch;

    // Directed plan. With default settings the grid sits 32 lines down and flush
    // left, so cell (0,0) starts at line 32, byte 61440; cell (79,25) starts at line
    // 432, byte 79*8*3 = 1896 into it. Glyph 0x00 and 0xff both start with 0x80,
    // so the leftmost pixel of their first row takes the foreground color.
    directed_plan = '{
      // After reset rendering is off: these two must produce no word at all.
      render_step(8'h00, 8'h0f, 7'd0,   5'd0,  1'b0, '0, '0),
      render_step(8'hff, 8'hf0, 7'd79,  5'd25, 1'b0, '0, '0),
      // Lowest and highest font store addresses.
      load_step(12'h000, 8'h80),
      load_step(12'hfff, 8'haa),
      config_step(CFG_RENDER_ENABLE, 15'd1),
      render_step(8'h00, 8'h0f, 7'd0,   5'd0,  1'b1, 23'h00f000, 24'hffffff),
      render_step(8'hff, 8'h0e, 7'd79,  5'd25, 1'b1, 23'h0caf68, 24'hffff00),
      render_step(8'h00, 8'hff, 7'd0,   5'd0,  1'b1, 23'h00f000, 24'hffffff),
      render_step(8'hff, 8'h00, 7'd0,   5'd0,  1'b1, 23'h00f000, 24'h000000),
      render_step(8'h00, 8'h21, 7'd40,  5'd12, 1'b0, '0, '0),
      // Cells inside, on and past the grid edge are placed by plain arithmetic.
      render_step(8'hff, 8'h43, 7'd127, 5'd31, 1'b0, '0, '0),
      render_step(8'h00, 8'h65, 7'd80,  5'd26, 1'b0, '0, '0),
      render_step(8'hff, 8'h87, 7'd1,   5'd1,  1'b0, '0, '0),
      render_step(8'h00, 8'ha9, 7'd64,  5'd16, 1'b0, '0, '0),
      render_step(8'hff, 8'hcb, 7'd15,  5'd8,  1'b0, '0, '0),
      render_step(8'h00, 8'hed, 7'd32,  5'd24, 1'b0, '0, '0),
      // Largest screen and pitch in the intended range.
      config_step(CFG_SCREEN_WIDTH,  15'd4096),
      config_step(CFG_SCREEN_HEIGHT, 15'd4096),
      config_step(CFG_LINE_PITCH,    15'd16384),
      render_step(8'hff, 8'h1e, 7'd79,  5'd25, 1'b0, '0, '0),
      // Screen smaller than the grid on both axes: no centring offset.
      config_step(CFG_SCREEN_WIDTH,  15'd320),
      config_step(CFG_SCREEN_HEIGHT, 15'd200),
      render_step(8'h00, 8'h3c, 7'd127, 5'd31, 1'b0, '0, '0),
      // Switched off again: the render is dropped.
      config_step(CFG_RENDER_ENABLE, 15'd0),
      render_step(8'hff, 8'h5b, 7'd10,  5'd10, 1'b0, '0, '0),
      config_step(CFG_RENDER_ENABLE, 15'd1)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Give glyphs 0x00 and 0xff full contents so the directed renders never touch
    // an unwritten font byte.
    for (int g = 0; g < 2; g++) begin
      ch = (g == 0) ? 8'h00 : 8'hff;
      for (int gy = 0; gy < GLYPH_HEIGHT_DEF; gy++) begin
        w = random_word();
        w.op = OP_LOAD;
        w.font_index = {ch, gy[3:0]};
        w.font_byte = ROW_PATTERNS[gy % 6];
        send_word(w);
      end
      glyph_ready[ch] = 1'b1;
      ready_chars.push_back(ch);
    end

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_CONFIG) begin
        write_register(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_word(directed_plan[i].word);
        // Replace the predicted first row with the hand-worked values.
        if (directed_plan[i].typed && exp_enable) begin
          k = pending_rows.size() - GLYPH_HEIGHT_DEF;
          r = pending_rows[k];
          r.addr = directed_plan[i].addr0;
          r.px[0] = directed_plan[i].pixel0;
          pending_rows[k] = r;
        end
      end
    end

    // Random part in four phases, each with its own screen setting and idle pattern:
    // none, a mostly idle sender, a mostly stalling receiver, then both a little.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_register(CFG_SCREEN_WIDTH,  15'd640);
          write_register(CFG_SCREEN_HEIGHT, 15'd480);
          write_register(CFG_LINE_PITCH,    15'd1920);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_register(CFG_SCREEN_WIDTH,  15'd4096);
          write_register(CFG_SCREEN_HEIGHT, 15'd416);
          write_register(CFG_LINE_PITCH,    15'd1920);
          send_idle_pct = 86;
          recv_stall_pct = 0;
        end
        2: begin
          // All ones in the screen size and pitch registers: addresses wrap often.
          write_register(CFG_SCREEN_WIDTH,  15'h1fff);
          write_register(CFG_SCREEN_HEIGHT, 15'h1fff);
          write_register(CFG_LINE_PITCH,    15'h7fff);
          send_idle_pct = 0;
          recv_stall_pct = 86;
        end
        default: begin
          write_register(CFG_SCREEN_WIDTH,  15'($urandom_range(4096, 640)));
          write_register(CFG_SCREEN_HEIGHT, 15'($urandom_range(4096, 416)));
          write_register(CFG_LINE_PITCH,    15'($urandom_range(16384, 1920)));
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase

      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Load a whole glyph, then it may be rendered.
          ch = 8'($urandom);
          for (int gy = 0; gy < GLYPH_HEIGHT_DEF; gy++) begin
            w = random_word();
            w.op = OP_LOAD;
            w.font_index = {ch, gy[3:0]};
            send_word(w);
          end
          if (!glyph_ready[ch]) begin
            glyph_ready[ch] = 1'b1;
            ready_chars.push_back(ch);
          end
          phase_words += GLYPH_HEIGHT_DEF;
        end else if (pick < 28) begin
          // A stray font byte anywhere in the store.
          w = random_word();
          w.op = OP_LOAD;
          send_word(w);
          phase_words++;
        end else begin
          // Render a glyph that is fully loaded; mostly on the grid, sometimes not.
          w = random_word();
          w.op = OP_RENDER;
          w.char_code = ready_chars[$urandom_range(ready_chars.size() - 1)];
          if ($urandom_range(99) >= 15) begin
            w.cell_col = 7'($urandom_range(GRID_COLS_DEF - 1));
            w.cell_row = 5'($urandom_range(GRID_ROWS_DEF - 1));
          end
          send_word(w);
          phase_words++;
        end
      end
    end

    wait_until_drained();
    $display("Run covered %0d font loads and %0d cell renders over %0d glyph sets,",
             loads_sent, renders_sent, ready_chars.size());
    $display("with %0d glyph row words checked across several screen settings.",
             rows_checked);
    if (fail_count == 0) begin
      $display("** text_cell_glyph_renderer_unit: PASSED **");
    end else begin
      $display("** text_cell_glyph_renderer_unit: FAILED **");
    end
    $finish;
  end

endmodule
